// ===== hdl/pst_pkg.sv =====
// ---------------------------------------------------------------------------
// pst_pkg
// shared widths and constants for the placement to scaled transform core
// ---------------------------------------------------------------------------
package pst_pkg;

    localparam int QFRAC  = 14;   // fraction bits of the rotation entries
    localparam int QW     = 16;   // quaternion, scale and rotation width
    localparam int PW     = 32;   // position width
    localparam int MW     = 31;   // scaled matrix entry width
    localparam int PRODW  = 32;   // raw 16x16 product width
    localparam int DEN_W  = 33;   // squared length, up to 2^32
    localparam int NUM_W  = 35;   // signed numerator width
    localparam int DVD_W  = DEN_W + QFRAC;   // rounded dividend width
    localparam int QBITS  = QFRAC + 1;       // quotient bits, up to 2^14
    localparam int NENT   = 9;

    // pipeline stages before the dividers and inside them
    localparam int NUM_STAGES = 3;
    localparam int DIV_STAGES = QBITS;

    typedef logic signed [QW-1:0]    q_t;
    typedef logic signed [PW-1:0]    pos_t;
    typedef logic signed [MW-1:0]    m_t;
    typedef logic        [DVD_W-1:0] dvd_t;
    typedef logic        [DEN_W-1:0] den_t;
    typedef logic        [QBITS-1:0] quo_t;

endpackage

// ===== hdl/pst_num.sv =====
// ---------------------------------------------------------------------------
// pst_num
// quaternion products, squared length and rounded dividends, three stages
// ---------------------------------------------------------------------------
module pst_num
(
    input  logic                                   clk,
    input  logic                                   en,
    input  pst_pkg::q_t                            quat_x,
    input  pst_pkg::q_t                            quat_y,
    input  pst_pkg::q_t                            quat_z,
    input  pst_pkg::q_t                            quat_w,
    output pst_pkg::dvd_t [pst_pkg::NENT-1:0]      dvd,
    output pst_pkg::den_t                          den,
    output logic          [pst_pkg::NENT-1:0]      neg
);
    import pst_pkg::*;

    typedef logic signed [PRODW-1:0] prod_t;
    typedef logic signed [NUM_W-1:0] num_t;

    prod_t xx_reg, yy_reg, zz_reg, ww_reg, xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    den_t  s_reg;
    num_t  num_reg [NENT];
    dvd_t  dvd_reg [NENT];
    dvd_t  dvd_next [NENT];
    den_t  den_reg, den_next;
    logic  [NENT-1:0] neg_reg, neg_next;

    function automatic num_t ext(input prod_t p);
        ext = NUM_W'(p);
    endfunction

    // stage 1: the ten products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            ww_reg <= quat_w * quat_w;
            xy_reg <= quat_x * quat_y;
            zw_reg <= quat_z * quat_w;
            xz_reg <= quat_x * quat_z;
            yw_reg <= quat_y * quat_w;
            yz_reg <= quat_y * quat_z;
            xw_reg <= quat_x * quat_w;
        end
    end

    // stage 2: squared length and numerators
    logic [DEN_W-1:0] s_sum;
    num_t             s_sn;
    assign s_sum = DEN_W'(unsigned'(xx_reg)) + DEN_W'(unsigned'(yy_reg))
                 + DEN_W'(unsigned'(zz_reg)) + DEN_W'(unsigned'(ww_reg));
    assign s_sn  = num_t'({2'b00, s_sum});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg      <= s_sum;
            num_reg[0] <= s_sn - ((ext(yy_reg) + ext(zz_reg)) <<< 1);
            num_reg[1] <= (ext(xy_reg) + ext(zw_reg)) <<< 1;
            num_reg[2] <= (ext(xz_reg) - ext(yw_reg)) <<< 1;
            num_reg[3] <= (ext(xy_reg) - ext(zw_reg)) <<< 1;
            num_reg[4] <= s_sn - ((ext(xx_reg) + ext(zz_reg)) <<< 1);
            num_reg[5] <= (ext(yz_reg) + ext(xw_reg)) <<< 1;
            num_reg[6] <= (ext(xz_reg) + ext(yw_reg)) <<< 1;
            num_reg[7] <= (ext(yz_reg) - ext(xw_reg)) <<< 1;
            num_reg[8] <= s_sn - ((ext(xx_reg) + ext(yy_reg)) <<< 1);
        end
    end

    // stage 3: magnitude, sign and rounding bias
    always_comb
    begin
        num_t mag;
        den_next = s_reg;
        for (int i = 0; i < NENT; i++)
        begin
            mag = num_reg[i][NUM_W-1] ? -num_reg[i] : num_reg[i];
            neg_next[i] = num_reg[i][NUM_W-1];
            dvd_next[i] = {mag[DEN_W-1:0], QFRAC'(0)} + DVD_W'(s_reg >> 1);
        end
        // zero quaternion: identity through a divide by one
        if (s_reg == '0)
        begin
            den_next = DEN_W'(1);
            for (int i = 0; i < NENT; i++)
            begin
                neg_next[i] = 1'b0;
                dvd_next[i] = (i % 4 == 0) ? (DVD_W'(1) << QFRAC) : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= den_next;
            neg_reg <= neg_next;
            for (int i = 0; i < NENT; i++)
            begin
                dvd_reg[i] <= dvd_next[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NENT; i++)
        begin
            dvd[i] = dvd_reg[i];
        end
    end
    assign den = den_reg;
    assign neg = neg_reg;

endmodule

// ===== hdl/pst_div.sv =====
// ---------------------------------------------------------------------------
// pst_div
// restoring divider, one quotient bit per pipeline stage
// ---------------------------------------------------------------------------
module pst_div
(
    input  logic           clk,
    input  logic           en,
    input  pst_pkg::dvd_t  dvd,
    input  pst_pkg::den_t  den,
    output pst_pkg::quo_t  quo
);
    import pst_pkg::*;

    dvd_t rem_reg [DIV_STAGES];
    den_t den_reg [DIV_STAGES];
    quo_t quo_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_stage
        dvd_t rem_in, trial, rem_next;
        den_t den_in;
        quo_t quo_in, quo_next;

        if (i == 0)
        begin : g_first
            assign rem_in = dvd;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        assign trial = DVD_W'(den_in) << (DIV_STAGES - 1 - i);

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                quo_next[DIV_STAGES-1-i] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                den_reg[i] <= den_in;
                quo_reg[i] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

// ===== hdl/placement_to_scaled_transform_core.sv =====
// an accepted beat passes pst_num, the dividers and the output register
// throughput: one beat per cycle unless stalled, set by the 15-stage dividers
// in_stall rises only while an output beat waits under out_stall
// reset clears the valid bits of every stage; data registers are not reset
// ---------------------------------------------------------------------------
// placement_to_scaled_transform_core
// quaternion placement to scaled rotation matrix plus translation
// ---------------------------------------------------------------------------
module placement_to_scaled_transform_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  pst_pkg::pos_t   pos_x,
    input  pst_pkg::pos_t   pos_y,
    input  pst_pkg::pos_t   pos_z,
    input  pst_pkg::q_t     scale_x,
    input  pst_pkg::q_t     scale_y,
    input  pst_pkg::q_t     scale_z,
    input  pst_pkg::q_t     quat_x,
    input  pst_pkg::q_t     quat_y,
    input  pst_pkg::q_t     quat_z,
    input  pst_pkg::q_t     quat_w,
    output logic            out_valid,
    input  logic            out_stall,
    output pst_pkg::m_t     m_00,
    output pst_pkg::m_t     m_01,
    output pst_pkg::m_t     m_02,
    output pst_pkg::m_t     m_10,
    output pst_pkg::m_t     m_11,
    output pst_pkg::m_t     m_12,
    output pst_pkg::m_t     m_20,
    output pst_pkg::m_t     m_21,
    output pst_pkg::m_t     m_22,
    output pst_pkg::pos_t   trans_x,
    output pst_pkg::pos_t   trans_y,
    output pst_pkg::pos_t   trans_z
);
    import pst_pkg::*;

    localparam int PIPE = NUM_STAGES + DIV_STAGES;

    logic              adv;
    logic [PIPE-1:0]   vld_reg, vld_next;
    logic              out_valid_reg;
    pos_t              px_reg [PIPE], py_reg [PIPE], pz_reg [PIPE];
    q_t                sx_reg [PIPE], sy_reg [PIPE], sz_reg [PIPE];
    dvd_t [NENT-1:0]   dvd;
    den_t              den;
    logic [NENT-1:0]   neg;
    logic [NENT-1:0]   neg_reg [DIV_STAGES];
    quo_t              quo [NENT];
    m_t                m_reg [NENT];
    pos_t              tx_reg, ty_reg, tz_reg;

    // whole pipeline moves unless a finished beat is held at the output
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;
    assign vld_next = {vld_reg[PIPE-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[PIPE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg[0] <= pos_x;
            py_reg[0] <= pos_y;
            pz_reg[0] <= pos_z;
            sx_reg[0] <= scale_x;
            sy_reg[0] <= scale_y;
            sz_reg[0] <= scale_z;
            for (int i = 1; i < PIPE; i++)
            begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
                pz_reg[i] <= pz_reg[i-1];
                sx_reg[i] <= sx_reg[i-1];
                sy_reg[i] <= sy_reg[i-1];
                sz_reg[i] <= sz_reg[i-1];
            end
            neg_reg[0] <= neg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    pst_num u_num
    (
        .clk    (clk),
        .en     (adv),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .quat_w (quat_w),
        .dvd    (dvd),
        .den    (den),
        .neg    (neg)
    );

    for (genvar e = 0; e < NENT; e++)
    begin : g_div
        pst_div u_div
        (
            .clk (clk),
            .en  (adv),
            .dvd (dvd[e]),
            .den (den),
            .quo (quo[e])
        );
    end

    // sign, then scale by the column's factor into the output register
    always_ff @(posedge clk)
    begin
        q_t r;
        q_t sc;
        logic signed [PRODW-1:0] p;
        if (adv)
        begin
            for (int e = 0; e < NENT; e++)
            begin
                r  = neg_reg[DIV_STAGES-1][e] ? -q_t'({1'b0, quo[e]}) : q_t'({1'b0, quo[e]});
                sc = (e % 3 == 0) ? sx_reg[PIPE-1] :
                     (e % 3 == 1) ? sy_reg[PIPE-1] : sz_reg[PIPE-1];
                p  = r * sc;
                m_reg[e] <= p[MW-1:0];
            end
            tx_reg <= px_reg[PIPE-1];
            ty_reg <= py_reg[PIPE-1];
            tz_reg <= pz_reg[PIPE-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign m_00 = m_reg[0];
    assign m_01 = m_reg[1];
    assign m_02 = m_reg[2];
    assign m_10 = m_reg[3];
    assign m_11 = m_reg[4];
    assign m_12 = m_reg[5];
    assign m_20 = m_reg[6];
    assign m_21 = m_reg[7];
    assign m_22 = m_reg[8];
    assign trans_x = tx_reg;
    assign trans_y = ty_reg;
    assign trans_z = tz_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output beat");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> out_valid == $past(vld_reg[PIPE-1]))
        else $error("output valid out of step with last stage");

endmodule
